@@ src/aafc_pkg.sv @@
`default_nettype none
package aafc_pkg;

  localparam int NUM_PLANES = 6;
  localparam int COORD_BITS = 16;
  localparam int COEF_BITS = 16;
  localparam int D_SHIFT = 14;
  localparam int CFG_DATA_BITS = 4 * COEF_BITS;
  localparam int CFG_INDEX_BITS = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int PROD_BITS = COORD_BITS + COEF_BITS;
  localparam int D_TERM_BITS = COEF_BITS + D_SHIFT;
  localparam int SUM_BITS = ((PROD_BITS > D_TERM_BITS) ? PROD_BITS : D_TERM_BITS) + 2;

  typedef struct packed {
    logic        last_box;
    logic signed [COORD_BITS-1:0] max_z;
    logic signed [COORD_BITS-1:0] max_y;
    logic signed [COORD_BITS-1:0] max_x;
    logic signed [COORD_BITS-1:0] min_z;
    logic signed [COORD_BITS-1:0] min_y;
    logic signed [COORD_BITS-1:0] min_x;
  } box_t;

  typedef struct packed {
    logic last_out;
    logic culled;
  } result_t;

  typedef struct packed {
    logic signed [COEF_BITS-1:0] d;
    logic signed [COEF_BITS-1:0] c;
    logic signed [COEF_BITS-1:0] b;
    logic signed [COEF_BITS-1:0] a;
  } plane_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

endpackage
`default_nettype wire

@@ src/aafc_plane_regs.sv @@
`default_nettype none
module aafc_plane_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [aafc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [aafc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  output aafc_pkg::plane_t [aafc_pkg::NUM_PLANES-1:0] planes
);
  import aafc_pkg::*;

  logic index_ok;

  assign index_ok = {1'b0, cfg_index} < (CFG_INDEX_BITS + 1)'(NUM_PLANES);

  always_ff @(posedge clk) begin
    if (rst) begin
      planes <= '0;
    end else if (cfg_wr_en && index_ok) begin
      planes[cfg_index] <= plane_t'(cfg_wdata);
    end
  end

endmodule
`default_nettype wire

@@ src/aafc_plane_eval.sv @@
`default_nettype none
module aafc_plane_eval (
  input  wire logic                clk,
  input  wire aafc_pkg::stage_en_t en,
  input  wire aafc_pkg::box_t      box,
  input  wire aafc_pkg::plane_t    plane,
  output logic                     reject
);
  import aafc_pkg::*;

  logic signed [COORD_BITS-1:0]  sel_x;
  logic signed [COORD_BITS-1:0]  sel_y;
  logic signed [COORD_BITS-1:0]  sel_z;
  logic signed [PROD_BITS-1:0]   prod_x;
  logic signed [PROD_BITS-1:0]   prod_y;
  logic signed [PROD_BITS-1:0]   prod_z;
  logic signed [D_TERM_BITS-1:0] d_term;
  logic signed [SUM_BITS-1:0]    sum;

  // The corner farthest along the normal takes max where the coefficient is not negative.
  assign sel_x = plane.a[COEF_BITS-1] ? box.min_x : box.max_x;
  assign sel_y = plane.b[COEF_BITS-1] ? box.min_y : box.max_y;
  assign sel_z = plane.c[COEF_BITS-1] ? box.min_z : box.max_z;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      prod_x <= PROD_BITS'(plane.a) * PROD_BITS'(sel_x);
      prod_y <= PROD_BITS'(plane.b) * PROD_BITS'(sel_y);
      prod_z <= PROD_BITS'(plane.c) * PROD_BITS'(sel_z);
      d_term <= $signed({plane.d, {D_SHIFT{1'b0}}});
    end
  end

  assign sum = SUM_BITS'(prod_x) + SUM_BITS'(prod_y) + SUM_BITS'(prod_z) + SUM_BITS'(d_term);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      reject <= sum[SUM_BITS-1];
    end
  end

endmodule
`default_nettype wire

@@ src/aabb_frustum_cull_core.sv @@
// Box-against-frustum cull test, one box per beat.
// Software loads the six planes through the write port (cfg_wr_en, cfg_index,
// cfg_wdata) while no boxes are in flight; each plane packs a, b and c in
// Q1.14 and d in the same format as the box coordinates. Writes to an index past the last plane
// are dropped.
// Boxes enter on in_valid/in_ready as min and max corners; each produces one
// result beat on out_valid/out_ready carrying the culled flag and a copy of
// the last_box marker, in input order.
// Four register stages lie between an accepted input beat and its result
// beat: input capture, corner select and multiply, four-term plane sum,
// and the final reduction across planes.
// Throughput is one box per cycle while the output side keeps taking beats.
// When the receiver stalls, the pipeline keeps filling its empty stages and
// in_ready drops only once every stage holds a box.
// Reset clears all planes to zero, so no box is culled until planes are
// written, and empties the pipeline.
`default_nettype none
module aabb_frustum_cull_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wr_en,
  input  wire logic [aafc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [aafc_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire aafc_pkg::box_t                     in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output aafc_pkg::result_t                       out_data
);
  import aafc_pkg::*;

  plane_t [NUM_PLANES-1:0] planes;
  logic   [NUM_PLANES-1:0] rejects;
  box_t      box_s1;
  logic      last_s2;
  logic      last_s3;
  logic      valid_s1;
  logic      valid_s2;
  logic      valid_s3;
  logic      adv_s1;
  logic      adv_s2;
  logic      adv_s3;
  logic      adv_out;
  stage_en_t stage_en;

  assign adv_out  = !out_valid || out_ready;
  assign adv_s3   = !valid_s3 || adv_out;
  assign adv_s2   = !valid_s2 || adv_s3;
  assign adv_s1   = !valid_s1 || adv_s2;
  assign in_ready = adv_s1;
  assign stage_en = '{s2: adv_s2, s3: adv_s3};

  aafc_plane_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes    (planes)
  );

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_plane
    aafc_plane_eval u_eval (
      .clk    (clk),
      .en     (stage_en),
      .box    (box_s1),
      .plane  (planes[p]),
      .reject (rejects[p])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s1  <= 1'b0;
      valid_s2  <= 1'b0;
      valid_s3  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_s1) begin
        valid_s1 <= in_valid;
      end
      if (adv_s2) begin
        valid_s2 <= valid_s1;
      end
      if (adv_s3) begin
        valid_s3 <= valid_s2;
      end
      if (adv_out) begin
        out_valid <= valid_s3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1) begin
      box_s1 <= in_data;
    end
    if (adv_s2) begin
      last_s2 <= box_s1.last_box;
    end
    if (adv_s3) begin
      last_s3 <= last_s2;
    end
    if (adv_out) begin
      out_data.culled   <= |rejects;
      out_data.last_out <= last_s3;
    end
  end

endmodule
`default_nettype wire
